### hdl/zefp_pkg.sv
package zefp_pkg;

   // Record ids that the parser recognizes.
   localparam logic [15:0] ID_ZIP64     = 16'h0001;
   localparam logic [15:0] ID_TIMESTAMP = 16'h5455;
   localparam logic [15:0] ID_UCOMMENT  = 16'h6375;
   localparam logic [15:0] ID_UPATH     = 16'h7075;

   // Flags byte bit that announces a modification time.
   localparam logic [7:0]  FLAG_MTIME    = 8'h01;
   // Header bytes of a record, and the shortest timestamp record with a time.
   localparam logic [15:0] HDR_BYTES     = 16'd4;
   localparam logic [15:0] MIN_TIME_LEN  = 16'd5;
   localparam logic [15:0] MAX_TIME_IDX  = 16'd4;

   // Status codes of the final block result.
   localparam logic [2:0] STATUS_OK            = 3'd0;
   localparam logic [2:0] STATUS_HDR_TRUNC     = 3'd1;
   localparam logic [2:0] STATUS_PAYLOAD_TRUNC = 3'd2;
   localparam logic [2:0] STATUS_NO_FLAGS      = 3'd3;
   localparam logic [2:0] STATUS_TIME_TRUNC    = 3'd4;

   // Result kinds.
   localparam logic RESULT_COPY   = 1'b0;
   localparam logic RESULT_STATUS = 1'b1;

   // Result queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;
   localparam logic [2:0] MAX_COPY = 3'd4;

   // Parse phases, one-hot.
   typedef enum logic [6:0] {
      PHASE_HDR0    = 7'b0000001,
      PHASE_HDR1    = 7'b0000010,
      PHASE_HDR2    = 7'b0000100,
      PHASE_HDR3    = 7'b0001000,
      PHASE_PAYLOAD = 7'b0010000,
      PHASE_FLAGS   = 7'b0100000,
      PHASE_TIME    = 7'b1000000
   } phase_type;

   // Input item.
   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] block_length;
      logic [31:0] fallback_time;
      logic        copy_unknown;
   } req_type;

   // Result item.
   typedef struct packed {
      logic        result_kind;
      logic [7:0]  out_byte;
      logic [31:0] mod_time;
      logic [2:0]  status;
      logic        last_of_block;
   } rsp_type;

   // All results of one input byte: up to four copied bytes, then maybe a status.
   typedef struct packed {
      logic [2:0]       copy_count;
      logic [3:0][7:0]  copy_bytes;
      logic             has_status;
      logic [2:0]       status;
      logic [31:0]      mod_time;
   } entry_type;

endpackage

### hdl/zefp_parse.sv
module zefp_parse
   import zefp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   input  logic      queue_full,
   output logic      push,
   output entry_type push_entry
);

   logic [15:0] pos_ff, pos_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] rec_id_ff, rec_id_in;
   logic [15:0] rec_len_ff, rec_len_in;
   logic [15:0] count_ff, count_in;
   logic        copy_ff, copy_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] found_ff, found_in;
   logic        time_found_ff, time_found_in;
   logic        err_latched_ff, err_latched_in;

   logic        accept;
   logic        last;
   logic [16:0] pos_plus1;
   logic [15:0] avail;
   logic [15:0] rec_len_full;
   logic [15:0] count_next;
   logic [7:0]  b;
   logic [2:0]  err;
   logic [2:0]  end_status;
   logic        known_id;
   logic        copy_now;

   // A new byte is taken whenever the result queue has room.
   assign req_stall = queue_full;
   assign accept    = req_valid & ~queue_full;

   assign b            = req_data.data_byte;
   assign pos_plus1    = {1'b0, pos_ff} + 17'd1;
   assign last         = pos_plus1 >= {1'b0, req_data.block_length};
   assign avail        = (req_data.block_length > pos_ff) ?
                         (req_data.block_length - pos_ff) : 16'd1;
   assign rec_len_full = {b, rec_len_ff[7:0]};
   assign count_next   = count_ff + 16'd1;
   assign known_id     = (rec_id_ff == ID_ZIP64) || (rec_id_ff == ID_UCOMMENT) ||
                         (rec_id_ff == ID_UPATH);

   // Record walk for one byte, and the results it causes.
   always_comb begin
      pos_in         = pos_ff;
      phase_in       = phase_ff;
      rec_id_in      = rec_id_ff;
      rec_len_in     = rec_len_ff;
      count_in       = count_ff;
      copy_in        = copy_ff;
      shift_in       = shift_ff;
      found_in       = found_ff;
      time_found_in  = time_found_ff;
      err_latched_in = err_latched_ff;
      err            = STATUS_OK;
      end_status     = STATUS_OK;
      copy_now       = 1'b0;
      push_entry     = '0;

      if (!err_latched_ff) begin
         unique case (phase_ff)
            PHASE_HDR0: begin
               if (avail < HDR_BYTES) begin
                  err = STATUS_HDR_TRUNC;
               end else begin
                  rec_id_in = {8'h00, b};
                  phase_in  = PHASE_HDR1;
               end
            end
            PHASE_HDR1: begin
               rec_id_in = {b, rec_id_ff[7:0]};
               phase_in  = PHASE_HDR2;
            end
            PHASE_HDR2: begin
               rec_len_in = {8'h00, b};
               phase_in   = PHASE_HDR3;
            end
            PHASE_HDR3: begin
               rec_len_in = rec_len_full;
               count_in   = '0;
               if (rec_len_full > (avail - 16'd1)) begin
                  err = STATUS_PAYLOAD_TRUNC;
               end else if (rec_id_ff == ID_TIMESTAMP) begin
                  copy_in = 1'b0;
                  if (rec_len_full == 16'd0) begin
                     err = STATUS_NO_FLAGS;
                  end else begin
                     phase_in = PHASE_FLAGS;
                  end
               end else begin
                  copy_now = ~known_id & req_data.copy_unknown;
                  copy_in  = copy_now;
                  if (copy_now) begin
                     push_entry.copy_count = MAX_COPY;
                     push_entry.copy_bytes = {b, rec_len_ff[7:0], rec_id_ff[15:8],
                                              rec_id_ff[7:0]};
                  end
                  phase_in = (rec_len_full != 16'd0) ? PHASE_PAYLOAD : PHASE_HDR0;
               end
            end
            PHASE_FLAGS: begin
               count_in = 16'd1;
               if ((b & FLAG_MTIME) != 8'h00) begin
                  if (rec_len_ff < MIN_TIME_LEN) begin
                     err = STATUS_TIME_TRUNC;
                  end else begin
                     shift_in = '0;
                     phase_in = PHASE_TIME;
                  end
               end else begin
                  phase_in = (rec_len_ff > 16'd1) ? PHASE_PAYLOAD : PHASE_HDR0;
               end
            end
            PHASE_TIME: begin
               // Time bytes are payload bytes one to four, little-endian.
               if ((count_ff >= 16'd1) && (count_ff <= MAX_TIME_IDX)) begin
                  unique case (count_ff[2:0])
                     3'd1: shift_in[7:0]   = shift_ff[7:0] | b;
                     3'd2: shift_in[15:8]  = shift_ff[15:8] | b;
                     3'd3: shift_in[23:16] = shift_ff[23:16] | b;
                     3'd4: begin
                        shift_in[31:24] = shift_ff[31:24] | b;
                        found_in        = {shift_ff[31:24] | b, shift_ff[23:0]};
                        time_found_in   = 1'b1;
                     end
                     default: ;
                  endcase
               end
               count_in = count_next;
               if (count_next >= rec_len_ff) begin
                  phase_in = PHASE_HDR0;
               end
            end
            default: begin
               // Payload byte of any other record.
               count_in = count_next;
               if (copy_ff) begin
                  push_entry.copy_count = 3'd1;
                  push_entry.copy_bytes = {24'h000000, b};
               end
               if (count_next >= rec_len_ff) begin
                  phase_in = PHASE_HDR0;
               end
            end
         endcase

         // Final status: an error at once, otherwise on the last byte.
         if (err != STATUS_OK) begin
            push_entry.has_status = 1'b1;
            push_entry.status     = err;
            push_entry.mod_time   = '0;
            err_latched_in        = 1'b1;
         end else if (last) begin
            if (phase_in == PHASE_HDR0) begin
               end_status = STATUS_OK;
            end else if ((phase_in == PHASE_HDR1) || (phase_in == PHASE_HDR2) ||
                         (phase_in == PHASE_HDR3)) begin
               end_status = STATUS_HDR_TRUNC;
            end else begin
               end_status = STATUS_PAYLOAD_TRUNC;
            end
            push_entry.has_status = 1'b1;
            push_entry.status     = end_status;
            if (end_status == STATUS_OK) begin
               push_entry.mod_time = time_found_in ? found_in : req_data.fallback_time;
            end else begin
               push_entry.mod_time = '0;
            end
         end
      end

      // The block state clears after its last byte.
      if (last) begin
         pos_in         = '0;
         phase_in       = PHASE_HDR0;
         rec_id_in      = '0;
         rec_len_in     = '0;
         count_in       = '0;
         copy_in        = 1'b0;
         shift_in       = '0;
         found_in       = '0;
         time_found_in  = 1'b0;
         err_latched_in = 1'b0;
      end else begin
         pos_in = pos_plus1[15:0];
      end
   end

   // Only bytes that cause results take a queue slot.
   assign push = accept & ((push_entry.copy_count != 3'd0) | push_entry.has_status);

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         phase_ff       <= PHASE_HDR0;
         rec_id_ff      <= '0;
         rec_len_ff     <= '0;
         count_ff       <= '0;
         copy_ff        <= 1'b0;
         shift_ff       <= '0;
         found_ff       <= '0;
         time_found_ff  <= 1'b0;
         err_latched_ff <= 1'b0;
      end else if (accept) begin
         pos_ff         <= pos_in;
         phase_ff       <= phase_in;
         rec_id_ff      <= rec_id_in;
         rec_len_ff     <= rec_len_in;
         count_ff       <= count_in;
         copy_ff        <= copy_in;
         shift_ff       <= shift_in;
         found_ff       <= found_in;
         time_found_ff  <= time_found_in;
         err_latched_ff <= err_latched_in;
      end
   end

`ifndef ASSERT_OFF
   // After an error, the rest of the block produces nothing.
   a_quiet_after_error: assert property (@(posedge clock) disable iff (reset)
      (accept && err_latched_ff) |-> !push)
      else $error("result produced after block error");

   // A queued entry holds at least one result and at most four copies.
   a_entry_shape: assert property (@(posedge clock) disable iff (reset)
      push |-> ((push_entry.copy_count <= MAX_COPY) &&
                ((push_entry.copy_count != 3'd0) || push_entry.has_status)))
      else $error("malformed queue entry");

   // The last byte of a block leaves a cleared parser behind.
   a_block_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> ((pos_ff == 16'd0) && !err_latched_ff && (phase_ff == PHASE_HDR0)))
      else $error("block state not cleared at block end");
`endif

endmodule

### hdl/zefp_outq.sv
module zefp_outq
   import zefp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   entry_type              entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [2:0]             sel_ff;
   logic [2:0]             sel_in;

   entry_type              head;
   logic [2:0]             head_total;
   logic                   xfer;
   logic                   pop;

   assign head       = entries_ff[rd_ptr_ff];
   assign head_total = head.copy_count + {2'b00, head.has_status};
   assign full       = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign rsp_valid  = count_ff != '0;
   assign xfer       = rsp_valid & ~rsp_stall;
   assign pop        = xfer & ((sel_ff + 3'd1) == head_total);

   // Current result of the head entry: copied bytes first, then the status.
   always_comb begin
      rsp_data = '0;
      if (sel_ff < head.copy_count) begin
         rsp_data.result_kind = RESULT_COPY;
         rsp_data.out_byte    = head.copy_bytes[sel_ff[1:0]];
      end else begin
         rsp_data.result_kind   = RESULT_STATUS;
         rsp_data.mod_time      = head.mod_time;
         rsp_data.status        = head.status;
         rsp_data.last_of_block = 1'b1;
      end
   end

   // Step through the head entry one transfer at a time.
   always_comb begin
      sel_in = sel_ff;
      if (pop) begin
         sel_in = '0;
      end else if (xfer) begin
         sel_in = sel_ff + 3'd1;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Pointers, fill count and result select.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sel_ff    <= '0;
      end else begin
         sel_ff <= sel_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`ifndef ASSERT_OFF
   // The fill count never passes the depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   // The select always points at a result the head entry holds.
   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (sel_ff < head_total))
      else $error("result select beyond head entry");

   // A write without a retire grows the queue by one.
   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == ($past(count_ff) + 1'b1)))
      else $error("result queue count lost a write");
`endif

endmodule

### hdl/zip_extra_field_parser.sv
// ZIP extra-field record parser.
// Input channel (req_valid, req_stall, req_data): one byte of the extra-field
// block per transfer, with the block length, the fallback time and the copy
// enable alongside. Result channel (rsp_valid, rsp_stall, rsp_data): copied
// record bytes, then one final status result per block with last_of_block set.
// Each byte is parsed in the cycle of its transfer; the results it causes are
// written as one entry into a four-entry result queue. The first result can be
// taken at the clock edge after the input transfer. A header byte of a copied
// record yields four results and a block's last byte may add a status, so one
// input byte gives zero to five results; the output side delivers one result
// per cycle unless stalled. Input bytes are taken every cycle while the queue
// has a free entry; req_stall is high exactly when the queue is full, so a long
// stall on rsp_stall backs up to the input after four result-bearing bytes.
// Reset clears the parser state and empties the queue; no memory clearing is
// needed, and the block accepts input in the first cycle after reset.
module zip_extra_field_parser
   import zefp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic      push;
   logic      queue_full;
   entry_type push_entry;

   // Byte-level record walk.
   zefp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Result queue and serializer.
   zefp_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

### sim/tb_zip_extra_field_parser.sv
`timescale 1ns / 1ps

module tb_zip_extra_field_parser;
   import zefp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 20;
   localparam int RANDOM_PER_RUN = 85;

   // Tracks the parser state byte by byte and holds the copies and block
   // status results that the accepted bytes are due to produce.
   class parser_scoreboard;
      rsp_type     due_q[$];
      logic [15:0] pos;
      logic [15:0] rec_id;
      logic [15:0] rec_len;
      logic [15:0] pay_cnt;
      phase_type   phase;
      logic        copying;
      logic [31:0] tshift;
      logic [31:0] found;
      logic        tfound;
      logic        err_latched;
      int          errors;
      int          bytes_in;
      int          copies_seen;
      int          status_seen;

      function new();
         clear_block();
         errors      = 0;
         bytes_in    = 0;
         copies_seen = 0;
         status_seen = 0;
      endfunction

      // Parser state at the start of a block.
      function void clear_block();
         pos         = '0;
         phase       = PHASE_HDR0;
         rec_id      = '0;
         rec_len     = '0;
         pay_cnt     = '0;
         copying     = 1'b0;
         tshift      = '0;
         found       = '0;
         tfound      = 1'b0;
         err_latched = 1'b0;
      endfunction

      function void push_copy(logic [7:0] value);
         rsp_type c;
         c             = '0;
         c.result_kind = RESULT_COPY;
         c.out_byte    = value;
         due_q.push_back(c);
      endfunction

      // Advance the parser by one accepted byte and queue what it causes.
      function void take_byte(req_type r);
         logic [31:0] blen;
         logic [31:0] avail;
         logic [31:0] idx;
         logic [2:0]  err;
         logic [2:0]  st;
         logic        is_last;
         rsp_type     s;
         bytes_in++;
         blen    = {16'h0, r.block_length};
         is_last = ({16'h0, pos} + 32'd1) >= blen;
         avail   = (blen > {16'h0, pos}) ? blen - {16'h0, pos} : 32'd1;
         err     = STATUS_OK;
         if (!err_latched) begin
            case (phase)
               PHASE_HDR0: begin
                  if (avail < {16'h0, HDR_BYTES}) begin
                     err = STATUS_HDR_TRUNC;
                  end else begin
                     rec_id = {8'h00, r.data_byte};
                     phase  = PHASE_HDR1;
                  end
               end
               PHASE_HDR1: begin
                  rec_id[15:8] = r.data_byte;
                  phase        = PHASE_HDR2;
               end
               PHASE_HDR2: begin
                  rec_len = {8'h00, r.data_byte};
                  phase   = PHASE_HDR3;
               end
               PHASE_HDR3: begin
                  rec_len[15:8] = r.data_byte;
                  pay_cnt       = '0;
                  if ({16'h0, rec_len} > avail - 32'd1) begin
                     err = STATUS_PAYLOAD_TRUNC;
                  end else if (rec_id == ID_TIMESTAMP) begin
                     copying = 1'b0;
                     if (rec_len == 16'd0) begin
                        err = STATUS_NO_FLAGS;
                     end else begin
                        phase = PHASE_FLAGS;
                     end
                  end else begin
                     // Known records are dropped; others follow the copy enable.
                     if (rec_id == ID_ZIP64 || rec_id == ID_UCOMMENT || rec_id == ID_UPATH) begin
                        copying = 1'b0;
                     end else begin
                        copying = r.copy_unknown;
                     end
                     if (copying) begin
                        push_copy(rec_id[7:0]);
                        push_copy(rec_id[15:8]);
                        push_copy(rec_len[7:0]);
                        push_copy(rec_len[15:8]);
                     end
                     phase = (rec_len != 16'd0) ? PHASE_PAYLOAD : PHASE_HDR0;
                  end
               end
               PHASE_FLAGS: begin
                  pay_cnt = 16'd1;
                  if ((r.data_byte & FLAG_MTIME) != 8'h00) begin
                     if (rec_len < MIN_TIME_LEN) begin
                        err = STATUS_TIME_TRUNC;
                     end else begin
                        tshift = '0;
                        phase  = PHASE_TIME;
                     end
                  end else begin
                     phase = (rec_len > 16'd1) ? PHASE_PAYLOAD : PHASE_HDR0;
                  end
               end
               PHASE_TIME: begin
                  // Payload bytes one to four build the little-endian time.
                  idx = {16'h0, pay_cnt};
                  if (idx >= 32'd1 && idx <= {16'h0, MAX_TIME_IDX}) begin
                     tshift = tshift | ({24'h0, r.data_byte} << (8 * (idx - 32'd1)));
                     if (idx == {16'h0, MAX_TIME_IDX}) begin
                        found  = tshift;
                        tfound = 1'b1;
                     end
                  end
                  pay_cnt = pay_cnt + 16'd1;
                  if (pay_cnt >= rec_len) begin
                     phase = PHASE_HDR0;
                  end
               end
               default: begin
                  pay_cnt = pay_cnt + 16'd1;
                  if (copying) begin
                     push_copy(r.data_byte);
                  end
                  if (pay_cnt >= rec_len) begin
                     phase = PHASE_HDR0;
                  end
               end
            endcase

            // An error ends the block at once; otherwise the last byte reports.
            st = err;
            if (err == STATUS_OK && is_last) begin
               case (phase)
                  PHASE_HDR0:                         st = STATUS_OK;
                  PHASE_HDR1, PHASE_HDR2, PHASE_HDR3: st = STATUS_HDR_TRUNC;
                  default:                            st = STATUS_PAYLOAD_TRUNC;
               endcase
            end
            if (err != STATUS_OK || is_last) begin
               s               = '0;
               s.result_kind   = RESULT_STATUS;
               s.status        = st;
               s.last_of_block = 1'b1;
               if (st == STATUS_OK) begin
                  s.mod_time = tfound ? found : r.fallback_time;
               end
               due_q.push_back(s);
               if (err != STATUS_OK) begin
                  err_latched = 1'b1;
               end
            end
         end

         if (is_last) begin
            clear_block();
         end else begin
            pos = pos + 16'd1;
         end
      endfunction

      function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      // Compare one result transfer against the oldest one due.
      function void match_output(rsp_type act);
         rsp_type exp_r;
         if (due_q.size() == 0) begin
            $display("%0t: result with nothing due: kind %0d byte 0x%0h time 0x%0h status %0d",
                     $time, act.result_kind, act.out_byte, act.mod_time, act.status);
            errors++;
            return;
         end
         exp_r = due_q.pop_front();
         check_field("result_kind", 32'(exp_r.result_kind), 32'(act.result_kind));
         check_field("out_byte", 32'(exp_r.out_byte), 32'(act.out_byte));
         check_field("mod_time", exp_r.mod_time, act.mod_time);
         check_field("status", 32'(exp_r.status), 32'(act.status));
         check_field("last_of_block", 32'(exp_r.last_of_block), 32'(act.last_of_block));
         if (exp_r.result_kind == RESULT_STATUS) begin
            status_seen++;
         end else begin
            copies_seen++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int send_idle_pct;
   int recv_idle_pct;
   int quiet_cycles = 0;
   int block_count;

   req_type          stim_q[$];
   logic [7:0]       blk[$];
   parser_scoreboard sb;

   zip_extra_field_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Result side: check each transfer and stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.match_output(rsp_data);
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Offer one byte, idling first at random, and hold it until it transfers.
   task automatic send_item(input req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sb.take_byte(item);
   endtask

   function automatic void add_header(logic [15:0] id, logic [15:0] len);
      blk.push_back(id[7:0]);
      blk.push_back(id[15:8]);
      blk.push_back(len[7:0]);
      blk.push_back(len[15:8]);
   endfunction

   // Turn the bytes gathered in blk into input items of one block.
   // copy_mode 0 or 1 fixes the copy enable, 2 draws it per byte.
   task automatic queue_block(input int blen, input logic [31:0] fb, input int copy_mode);
      req_type r;
      foreach (blk[i]) begin
         r.data_byte     = blk[i];
         r.block_length  = blen[15:0];
         r.fallback_time = fb;
         r.copy_unknown  = (copy_mode == 2) ? 1'($urandom_range(0, 1)) : copy_mode[0];
         stim_q.push_back(r);
      end
      blk.delete();
      block_count++;
   endtask

   // A block of random records, some of them malformed timestamps, cut short now and then.
   task automatic random_block();
      int          nrec;
      int          kind;
      int          len;
      int          cut;
      logic [15:0] id;
      logic [7:0]  flags;
      nrec = $urandom_range(1, 4);
      repeat (nrec) begin
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            case (kind)
               4:       id = ID_ZIP64;
               5:       id = ID_UCOMMENT;
               6:       id = ID_UPATH;
               default: begin
                  id = 16'($urandom);
                  while (id == ID_ZIP64 || id == ID_UCOMMENT || id == ID_UPATH ||
                         id == ID_TIMESTAMP) begin
                     id = 16'($urandom);
                  end
               end
            endcase
            len = $urandom_range(0, 6);
            add_header(id, 16'(len));
            repeat (len) blk.push_back(8'($urandom));
         end else if ($urandom_range(0, 3) != 0) begin
            // Timestamp record that carries a full time.
            len = 5 + $urandom_range(0, 4);
            add_header(ID_TIMESTAMP, 16'(len));
            flags    = 8'($urandom);
            flags[0] = 1'b1;
            blk.push_back(flags);
            repeat (len - 1) blk.push_back(8'($urandom));
         end else begin
            // Timestamp record of any short length with random flags.
            len = $urandom_range(0, 6);
            add_header(ID_TIMESTAMP, 16'(len));
            repeat (len) blk.push_back(8'($urandom));
         end
      end
      cut = blk.size();
      if ($urandom_range(0, 3) == 0) begin
         cut = $urandom_range(1, blk.size());
         while (blk.size() > cut) begin
            void'(blk.pop_back());
         end
      end
      queue_block(cut, $urandom, 2);
   endtask

   // Random bytes whose block length jumps about; the last byte ends the block.
   task automatic noise_block();
      int      n;
      req_type r;
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
         r.data_byte     = 8'($urandom);
         r.block_length  = (i == n - 1) ? 16'd1 : 16'($urandom);
         r.fallback_time = $urandom;
         r.copy_unknown  = 1'($urandom_range(0, 1));
         stim_q.push_back(r);
      end
      block_count++;
   endtask

   initial begin
      int target;
      sb            = new();
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      block_count   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 19;
               recv_idle_pct = 74;
            end
            1: begin
               send_idle_pct = 74;
               recv_idle_pct = 19;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         if (p == 0) begin
            // Zero block length acts as one byte: header truncated at once.
            blk = '{8'hFF};
            queue_block(0, 32'hFFFF_FFFF, 1);
            // Copied unknown record with all-ones id and a zero payload byte.
            blk = '{8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00};
            queue_block(5, 32'h0000_0000, 1);
            // Timestamp record whose time replaces the fallback.
            blk = '{8'h55, 8'h54, 8'h05, 8'h00, 8'h01, 8'h78, 8'h56, 8'h34, 8'h12};
            queue_block(9, 32'hFFFF_FFFF, 1);
            // Copies stay sent, then a path record whose payload overruns the block.
            blk = '{8'h34, 8'h12, 8'h00, 8'h00, 8'h75, 8'h70, 8'h09, 8'h00, 8'hAA};
            queue_block(9, 32'h1357_9BDF, 1);
         end

         target = stim_q.size() + RANDOM_PER_RUN;
         while (stim_q.size() < target) begin
            if ($urandom_range(0, 4) == 0) begin
               noise_block();
            end else begin
               random_block();
            end
         end

         while (stim_q.size() > 0) begin
            send_item(stim_q.pop_front());
         end
         req_valid <= 1'b0;
         @(posedge clock);
         while (sb.due_q.size() > 0) begin
            @(posedge clock);
         end
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.due_q.size() > 0) begin
         $display("%0t: %0d results never arrived", $time, sb.due_q.size());
         sb.errors += sb.due_q.size();
      end

      $display("Streamed %0d bytes in %0d blocks under three idle patterns.",
               sb.bytes_in, block_count);
      $display("Checked %0d copied bytes and %0d block status results, %0d mismatches.",
               sb.copies_seen, sb.status_seen, sb.errors);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
